[hw/rtl/surface_to_host_midi_translator_assert.svh]
// assertion macros used by the translator top level
`ifndef SURFACE_TO_HOST_MIDI_TRANSLATOR_ASSERT_SVH
`define SURFACE_TO_HOST_MIDI_TRANSLATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define STHM_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define STHM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/sthm_pkg.sv]
// types, byte codes and note rom shared by the translator modules
`timescale 1ns / 1ps
`default_nettype none

package sthm_pkg;

	// feedback prefix sent back to the surface
	localparam logic [1:0] FB_NONE = 2'd0;
	localparam logic [1:0] FB_SEND = 2'd1;
	localparam logic [1:0] FB_PAN  = 2'd2;

	// body kinds emitted to the host
	localparam logic [1:0] KIND_SWITCH = 2'd0;
	localparam logic [1:0] KIND_THREE  = 2'd1;
	localparam logic [1:0] KIND_BEND   = 2'd2;

	// byte values
	localparam logic [7:0] BYTE_CC       = 8'd176;
	localparam logic [7:0] BYTE_NOTE_OFF = 8'd128;
	localparam logic [7:0] BYTE_NOTE_ON  = 8'd144;
	localparam logic [7:0] BYTE_ZONE_SEL = 8'd15;
	localparam logic [7:0] BYTE_PORT_SEL = 8'd47;
	localparam logic [7:0] BYTE_JOG      = 8'd13;
	localparam logic [7:0] BYTE_FULL     = 8'd127;
	localparam logic [7:0] BYTE_HALF     = 8'd64;
	localparam logic [7:0] BYTE_ZERO     = 8'd0;
	localparam logic [7:0] BYTE_SEND_OFF = 8'd42;
	localparam logic [7:0] BYTE_PAN_NOTE = 8'd41;
	localparam logic [7:0] BEND_LOW_OFS  = 8'd32;
	localparam logic [7:0] KNOB_OFS      = 8'd48;

	// note numbers with special meaning
	localparam logic [6:0] NOTE_SCRUB     = 7'd101;
	localparam logic [6:0] NOTE_SW_A      = 7'd54;
	localparam logic [6:0] NOTE_SW_B      = 7'd58;
	localparam logic [6:0] NOTE_MODE_LO   = 7'd41;
	localparam logic [6:0] NOTE_MODE_HI   = 7'd44;
	localparam logic [6:0] NOTE_SEND      = 7'd41;
	localparam logic [6:0] NOTE_PAN       = 7'd42;
	localparam logic [6:0] NOTE_PAN_TGT   = 7'd119;
	localparam logic [6:0] VEL_FULL       = 7'd127;
	localparam logic [6:0] CC_KNOB_LO     = 7'd16;
	localparam logic [6:0] CC_KNOB_HI     = 7'd23;
	localparam logic [6:0] CC_JOG         = 7'd60;
	localparam logic [6:0] JOG_FWD        = 7'd1;
	localparam logic [6:0] JOG_REV        = 7'd65;

	// default depth of the command queue
	localparam int QUEUE_DEPTH_DEF = 4;

	// one queued command for the emitter
	typedef struct packed {
		logic [1:0] fb;
		logic [1:0] kind;
		logic [7:0] a;
		logic [7:0] b;
		logic [6:0] c;
	} cmd_t;

	// rom entry: mapped flag, zone, port
	function automatic logic [8:0] mv(input int zone, input int port);
		logic [31:0] z;
		logic [31:0] p;
		z = zone;
		p = port;
		return {1'b1, z[4:0], p[2:0]};
	endfunction

	localparam logic [8:0] NM = 9'd0;

	localparam logic [8:0] NOTE_ROM [128] = '{
		mv(0,7), mv(1,7), mv(2,7), mv(3,7), mv(4,7), mv(5,7), mv(6,7), mv(7,7),
		mv(0,3), mv(1,3), mv(2,3), mv(3,3), mv(4,3), mv(5,3), mv(6,3), mv(7,3),
		mv(0,2), mv(1,2), mv(2,2), mv(3,2), mv(4,2), mv(5,2), mv(6,2), mv(7,2),
		mv(0,1), mv(1,1), mv(2,1), mv(3,1), mv(4,1), mv(5,1), mv(6,1), mv(7,1),
		mv(0,5), mv(1,5), mv(2,5), mv(3,5), mv(4,5), mv(5,5), mv(6,5), mv(7,5),
		mv(23,2), mv(23,4), mv(23,1), NM, NM, NM, mv(10,1), mv(10,3),
		mv(10,0), mv(10,2), mv(12,3), mv(26,0), mv(26,1), mv(26,2), mv(27,0), mv(27,1),
		mv(27,2), mv(27,3), mv(27,4), mv(27,5), mv(27,6), mv(27,7), NM, NM,
		NM, NM, NM, NM, NM, NM, mv(8,1), mv(8,5),
		mv(8,0), mv(8,4), mv(24,2), mv(24,4), mv(24,0), mv(24,5), mv(24,1), mv(12,3),
		mv(8,7), mv(8,3), mv(27,7), mv(20,0), mv(20,0), mv(26,3), mv(15,3), mv(20,0),
		mv(26,4), mv(21,0), mv(26,5), mv(14,1), mv(14,2), mv(14,3), mv(14,4), mv(14,5),
		mv(13,4), mv(13,0), mv(13,1), mv(13,3), mv(13,2), mv(13,5), mv(13,6), NM,
		NM, NM, NM, NM, NM, NM, NM, mv(12,4),
		mv(28,0), NM, mv(11,7), mv(11,6), mv(11,5), mv(11,4), mv(11,3), mv(11,2),
		mv(0,4), mv(1,4), mv(2,4), mv(3,4), mv(4,4), mv(5,4), mv(6,4), mv(7,4)
	};

endpackage

`default_nettype wire

[hw/rtl/surface_to_host_midi_translator.sv]
// top level: surface midi to host zone/port byte stream translator
//
//   channel   dir  payload                                       marker
//   s_axis    in   status[7:0] data_one[14:8] data_two[21:15]    -
//   m_axis    out  out_byte[7:0], tuser = to_source              tlast on final byte
//
// the emitter sends one byte per cycle while the output is not stalled; an item is
// 3, 6, 9, 12 or 18 bytes long at the output, set by the length of its byte sequence
// the front end takes one beat per cycle while the command queue has room
// beats that produce nothing are still accepted and leave no command
// arst_n clears modes, scrub phase, queue and emitter; payload is not reset
// an output stall holds the emitter while the front end keeps filling the queue
`timescale 1ns / 1ps
`default_nettype none

`include "surface_to_host_midi_translator_assert.svh"

module surface_to_host_midi_translator #(
	parameter int QUEUE_DEPTH = sthm_pkg::QUEUE_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,    // status[7:0], data_one[14:8], data_two[21:15]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,    // out_byte[7:0]
	output logic        m_tuser,    // to_source
	output logic        m_tlast
);
	import sthm_pkg::*;

	cmd_t push_cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	logic busy;

	// classify incoming beats
	sthm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_cmd)
	);

	// decouple front end from emitter
	sthm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// emit bytes
	sthm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (q_empty),
		.pop      (pop),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// checks
	`STHM_ASSERT_NOW(a_no_push_full, push, !q_full, "command pushed into full queue")
	`STHM_ASSERT_NEXT(a_pickup, !busy && !q_empty, busy, "emitter left pending command")
	`STHM_ASSERT_NOW(a_fb_not_last, m_tvalid && m_tuser, !m_tlast, "feedback beat marked last")

endmodule

`default_nettype wire

[hw/rtl/sthm_front.sv]
// front end: accepts midi beats, tracks modes and scrub, builds commands
`timescale 1ns / 1ps
`default_nettype none

module sthm_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [23:0]          s_tdata,   // status[7:0], data_one[14:8], data_two[21:15]
	input  wire                  q_full,
	output logic                 push,
	output sthm_pkg::cmd_t       cmd
);
	import sthm_pkg::*;

	logic [1:0] scrub_phase_q;
	logic       send_mode_q;
	logic       pan_mode_q;

	logic [7:0] status;
	logic [6:0] d1;
	logic [6:0] d2;
	logic       accept;
	logic       is_note, is_cc, is_bend;
	logic       on;
	logic       scrub_hit;
	logic       rom_hit;
	logic       mode_note;
	logic       send_n, pan_n;
	logic [6:0] note2;
	logic [8:0] entry;
	logic       emit;
	logic       note_path;
	logic [7:0] flipped;

	assign status = s_tdata[7:0];
	assign d1     = s_tdata[14:8];
	assign d2     = s_tdata[21:15];

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	assign is_note = (status[7:5] == 3'b100);
	assign is_cc   = (status[7:4] == 4'hB);
	assign is_bend = (status[7:4] == 4'hE);

	assign on        = (d2 == VEL_FULL);
	assign scrub_hit = (d1 == NOTE_SCRUB) && on;
	assign rom_hit   = NOTE_ROM[d1][8];
	assign mode_note = (d1 >= NOTE_MODE_LO) && (d1 <= NOTE_MODE_HI);
	// mapped path: not scrub and not the two fixed switches
	assign note_path = !scrub_hit && (d1 != NOTE_SW_A) && (d1 != NOTE_SW_B) && rom_hit;

	// value above or below center: same as +64 / -64, and as 66-value for the jog codes
	assign flipped = {1'b0, ~d2[6], d2[5:0]};

	// mode after this note
	always_comb begin
		send_n = send_mode_q;
		pan_n  = pan_mode_q;
		if (note_path && mode_note) begin
			send_n = (d1 == NOTE_SEND);
			pan_n  = (d1 == NOTE_PAN);
		end
	end

	// remap under the knob mode
	always_comb begin
		note2 = d1;
		if (send_n) begin
			if (d1 == 7'd40) begin
				note2 = 7'd79;
			end else if (d1 == 7'd45) begin
				note2 = 7'd111;
			end else if (d1 >= 7'd74 && d1 <= 7'd78) begin
				note2 = d1 + 7'd40;
			end
		end else if (pan_n) begin
			note2 = NOTE_PAN_TGT;
		end
	end

	assign entry = NOTE_ROM[note2];

	// classify the beat into one command
	always_comb begin
		emit     = 1'b0;
		cmd.fb   = FB_NONE;
		cmd.kind = KIND_SWITCH;
		cmd.a    = 8'd0;
		cmd.b    = 8'd0;
		cmd.c    = 7'd0;
		if (is_note) begin
			if (scrub_hit) begin
				emit = (scrub_phase_q != 2'd3);
				case (scrub_phase_q)
					2'd0: begin
						cmd.a = 8'd13;
						cmd.b = 8'd5 + BYTE_HALF;
					end
					2'd1: begin
						cmd.a = 8'd13;
						cmd.b = 8'd6 + BYTE_HALF;
					end
					default: begin
						cmd.a = 8'd14;
						cmd.b = 8'd3 + BYTE_HALF;
					end
				endcase
			end else if (d1 == NOTE_SW_A || d1 == NOTE_SW_B) begin
				emit  = 1'b1;
				cmd.a = 8'd8;
				cmd.b = {1'b0, on, 3'b000, (d1 == NOTE_SW_A) ? 3'd2 : 3'd6};
			end else if (rom_hit) begin
				emit   = 1'b1;
				cmd.fb = send_n ? FB_SEND : (pan_n ? FB_PAN : FB_NONE);
				cmd.a  = {3'b000, entry[7:3]};
				cmd.b  = {1'b0, on, 3'b000, entry[2:0]};
			end
		end else if (is_cc) begin
			cmd.kind = KIND_THREE;
			cmd.b    = flipped;
			if (d1 >= CC_KNOB_LO && d1 <= CC_KNOB_HI) begin
				emit  = 1'b1;
				cmd.a = {1'b0, d1} + KNOB_OFS;
			end else if (d1 == CC_JOG && (d2 == JOG_FWD || d2 == JOG_REV)) begin
				emit  = 1'b1;
				cmd.a = BYTE_JOG;
			end
		end else if (is_bend) begin
			emit     = 1'b1;
			cmd.kind = KIND_BEND;
			cmd.a    = {4'b0000, status[3:0]};
			cmd.b    = {1'b0, d2};
			cmd.c    = d1;
		end
	end

	assign push = accept && emit;

	// mode and scrub state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scrub_phase_q <= 2'd0;
			send_mode_q   <= 1'b0;
			pan_mode_q    <= 1'b0;
		end else if (accept && is_note) begin
			if (scrub_hit) begin
				scrub_phase_q <= (scrub_phase_q >= 2'd2) ? 2'd0 : scrub_phase_q + 2'd1;
			end
			send_mode_q <= send_n;
			pan_mode_q  <= pan_n;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/sthm_queue.sv]
// short command queue between front end and emitter
`timescale 1ns / 1ps
`default_nettype none

module sthm_queue #(
	parameter int DEPTH = sthm_pkg::QUEUE_DEPTH_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  sthm_pkg::cmd_t   push_data,
	input  wire              pop,
	output sthm_pkg::cmd_t   head,
	output logic             full,
	output logic             empty
);
	import sthm_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/sthm_back.sv]
// emitter: walks one command and sends its bytes one beat per cycle while the output is not stalled
`timescale 1ns / 1ps
`default_nettype none

module sthm_back (
	input  wire              clk,
	input  wire              arst_n,
	input  sthm_pkg::cmd_t   head,
	input  wire              q_empty,
	output logic             pop,
	output logic             busy,
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [7:0]       m_tdata,   // out_byte[7:0]
	output logic             m_tuser,   // to_source
	output logic             m_tlast
);
	import sthm_pkg::*;

	cmd_t       cur_q;
	logic       busy_q;
	logic       body_q;     // 0 feedback section, 1 host section
	logic [2:0] grp_q;
	logic [1:0] sub_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_src_q;
	logic       out_last_q;

	logic       adv;
	logic       grp_last;
	logic       final_byte;
	logic [7:0] byte_val;
	logic       load;

	assign busy     = busy_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_src_q;
	assign m_tlast  = out_last_q;

	assign adv = busy_q && (!out_valid_q || m_tready);

	// last group of the current section
	always_comb begin
		if (!body_q) begin
			grp_last = (cur_q.fb == FB_SEND) ? (grp_q == 3'd1) : (grp_q == 3'd0);
		end else begin
			case (cur_q.kind)
				KIND_SWITCH: grp_last = (grp_q == 3'd1);
				KIND_BEND:   grp_last = (grp_q == 3'd5);
				default:     grp_last = (grp_q == 3'd0);
			endcase
		end
	end

	assign final_byte = body_q && grp_last && (sub_q == 2'd2);
	assign load       = !q_empty && (!busy_q || (adv && final_byte));
	assign pop        = load;

	// byte for the current position
	always_comb begin
		byte_val = BYTE_ZERO;
		if (!body_q) begin
			if (sub_q == 2'd0) begin
				byte_val = (grp_q == 3'd0) ? BYTE_NOTE_OFF : BYTE_NOTE_ON;
			end else if (sub_q == 2'd1) begin
				byte_val = (cur_q.fb == FB_SEND && grp_q == 3'd0) ? BYTE_SEND_OFF
					: BYTE_PAN_NOTE;
			end else begin
				byte_val = (cur_q.fb == FB_SEND && grp_q == 3'd1) ? BYTE_FULL : BYTE_ZERO;
			end
		end else if (sub_q == 2'd0) begin
			byte_val = BYTE_CC;
		end else begin
			case (cur_q.kind)
				KIND_SWITCH: begin
					if (sub_q == 2'd1) begin
						byte_val = (grp_q == 3'd0) ? BYTE_ZONE_SEL : BYTE_PORT_SEL;
					end else begin
						byte_val = (grp_q == 3'd0) ? cur_q.a : cur_q.b;
					end
				end
				KIND_BEND: begin
					case (grp_q)
						3'd0, 3'd4: byte_val = (sub_q == 2'd1) ? BYTE_ZONE_SEL : cur_q.a;
						3'd1:       byte_val = (sub_q == 2'd1) ? BYTE_PORT_SEL : BYTE_HALF;
						3'd2:       byte_val = (sub_q == 2'd1) ? cur_q.a : cur_q.b;
						3'd3:       byte_val = (sub_q == 2'd1) ? cur_q.a + BEND_LOW_OFS
							: {1'b0, cur_q.c};
						default:    byte_val = (sub_q == 2'd1) ? BYTE_PORT_SEL : BYTE_ZERO;
					endcase
				end
				default: begin
					byte_val = (sub_q == 2'd1) ? cur_q.a : cur_q.b;
				end
			endcase
		end
	end

	// current command and walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			body_q <= 1'b0;
			grp_q  <= 3'd0;
			sub_q  <= 2'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			body_q <= (head.fb == FB_NONE);
			grp_q  <= 3'd0;
			sub_q  <= 2'd0;
		end else if (adv) begin
			if (final_byte) begin
				busy_q <= 1'b0;
			end else if (sub_q == 2'd2) begin
				sub_q <= 2'd0;
				if (grp_last) begin
					body_q <= 1'b1;
					grp_q  <= 3'd0;
				end else begin
					grp_q <= grp_q + 3'd1;
				end
			end else begin
				sub_q <= sub_q + 2'd1;
			end
		end
	end

	// command payload
	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= head;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= byte_val;
			out_src_q  <= !body_q;
			out_last_q <= final_byte;
		end
	end

endmodule

`default_nettype wire
